// ----- hdl/sdet_pkg.sv -----
package sdet_pkg;

    localparam int TimeW   = 32;   // internal time and duration arithmetic width
    localparam int NowW    = 32;   // width of the time field on the input channel
    localparam int DurW    = 32;   // width of the reported durations
    localparam int MinW    = 16;   // width of the minimum hold registers
    localparam int CfgIdxW = 8;
    localparam int CmpW    = (TimeW > MinW) ? TimeW : MinW;

    localparam logic [MinW-1:0] MinPressRst   = 16'd50;
    localparam logic [MinW-1:0] MinReleaseRst = 16'd50;

    typedef logic [TimeW-1:0]   t_time;
    typedef logic [NowW-1:0]    t_now;
    typedef logic [DurW-1:0]    t_dur;
    typedef logic [MinW-1:0]    t_min;
    typedef logic [CmpW-1:0]    t_cmp;
    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MIN_PRESS   = 8'd0,
        REG_MIN_RELEASE = 8'd1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        PH_RELEASED     = 4'b0001,
        PH_PEND_PRESS   = 4'b0010,
        PH_PRESSED      = 4'b0100,
        PH_PEND_RELEASE = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase phase;
        t_time  press_start;
        t_time  release_start;
        t_time  pressed_ms;
        t_time  released_ms;
        logic   debounced;
        logic   press_pulse;
        logic   release_pulse;
    } t_state;

endpackage

// ----- hdl/sdet_ifs.sv -----
interface sdet_in_if;
    logic              valid;
    logic              ready;
    logic              level_high;
    sdet_pkg::t_now    now_ms;

    modport source (output valid, output level_high, output now_ms, input ready);
    modport sink   (input valid, input level_high, input now_ms, output ready);
endinterface

interface sdet_out_if;
    logic              valid;
    logic              ready;
    logic              is_pressed;
    logic              press_event;
    logic              release_event;
    sdet_pkg::t_dur    pressed_duration;
    sdet_pkg::t_dur    released_duration;

    modport source (output valid, output is_pressed, output press_event,
                    output release_event, output pressed_duration,
                    output released_duration, input ready);
    modport sink   (input valid, input is_pressed, input press_event,
                    input release_event, input pressed_duration,
                    input released_duration, output ready);
endinterface

interface sdet_cfg_if;
    logic                 valid;
    logic                 ready;
    sdet_pkg::t_cfg_idx   index;
    sdet_pkg::t_min       wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- hdl/sdet_step.sv -----
module sdet_step (
    input  sdet_pkg::t_state i_state,
    input  logic             i_level_high,
    input  sdet_pkg::t_time  i_now,
    input  sdet_pkg::t_min   i_min_press,
    input  sdet_pkg::t_min   i_min_release,
    output sdet_pkg::t_state o_state
);

    sdet_pkg::t_time el_press;
    sdet_pkg::t_time el_release;
    logic            press_held;
    logic            release_held;

    // wrap-around differences, modulo 2^TimeW
    assign el_press     = i_now - i_state.press_start;
    assign el_release   = i_now - i_state.release_start;
    assign press_held   = sdet_pkg::t_cmp'(el_press) > sdet_pkg::t_cmp'(i_min_press);
    assign release_held = sdet_pkg::t_cmp'(el_release) > sdet_pkg::t_cmp'(i_min_release);

    always_comb begin
        o_state = i_state;
        unique case (i_state.phase)
            sdet_pkg::PH_RELEASED: begin
                o_state.release_pulse = 1'b0;
                if (!i_level_high) begin
                    o_state.phase       = sdet_pkg::PH_PEND_PRESS;
                    o_state.press_start = i_now;
                end else begin
                    o_state.released_ms = el_release;
                end
            end
            sdet_pkg::PH_PEND_PRESS: begin
                if (i_level_high) begin
                    o_state.phase = sdet_pkg::PH_RELEASED;
                end else if (press_held) begin
                    o_state.phase       = sdet_pkg::PH_PRESSED;
                    o_state.debounced   = 1'b1;
                    o_state.press_pulse = 1'b1;
                    o_state.released_ms = el_release;
                end
            end
            sdet_pkg::PH_PRESSED: begin
                o_state.press_pulse = 1'b0;
                if (i_level_high) begin
                    o_state.phase         = sdet_pkg::PH_PEND_RELEASE;
                    o_state.release_start = i_now;
                end else begin
                    o_state.pressed_ms = el_press;
                end
            end
            sdet_pkg::PH_PEND_RELEASE: begin
                if (!i_level_high) begin
                    o_state.phase = sdet_pkg::PH_PRESSED;
                end else if (release_held) begin
                    o_state.phase         = sdet_pkg::PH_RELEASED;
                    o_state.pressed_ms    = el_press;
                    o_state.debounced     = 1'b0;
                    o_state.release_pulse = 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ----- hdl/switch_debounce_edge_timer.sv -----
// Switch debouncer with press and release duration tracking.
//
// i_in  : one transaction per pin sample: level_high (0 = pressed) and now_ms,
//         a free-running millisecond count that wraps modulo 2^32.
// o_out : one transaction per input transaction, in order: debounced state,
//         one-transaction press/release pulses and the current or last press
//         and release durations in milliseconds.
// i_cfg : register writes, index 0 = min_press_ms, 1 = min_release_ms; other
//         indexes are dropped. Always ready. Write only while idle.
//
// o_out.valid rises once an accepted sample has passed from the input register
// into the output register. Throughput is one transaction per cycle while o_out
// is not stalled: the sample sits in an input register, and one step of the
// debounce state machine (two subtractions and two compares) runs between it
// and the output register. When o_out is stalled the output register holds,
// the input register fills behind it, and i_in.ready drops until o_out drains.
// Reset returns the machine to confirmed released with all times and
// durations zero and both minimums at 50 ms; no clearing pass is needed.
module switch_debounce_edge_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdet_in_if.sink     i_in,
    sdet_out_if.source  o_out,
    sdet_cfg_if.sink    i_cfg
);

    logic             r_in_valid;
    logic             r_level;
    sdet_pkg::t_time  r_now;
    sdet_pkg::t_state r_st;
    sdet_pkg::t_state n_st;
    logic             r_out_valid;
    logic             r_is_pressed;
    logic             r_press_event;
    logic             r_release_event;
    sdet_pkg::t_dur   r_pressed_dur;
    sdet_pkg::t_dur   r_released_dur;
    sdet_pkg::t_min   r_min_press;
    sdet_pkg::t_min   r_min_release;
    logic             advance;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_press   <= sdet_pkg::MinPressRst;
            r_min_release <= sdet_pkg::MinReleaseRst;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == sdet_pkg::REG_MIN_PRESS) begin
                r_min_press <= i_cfg.wdata;
            end
            if (i_cfg.index == sdet_pkg::REG_MIN_RELEASE) begin
                r_min_release <= i_cfg.wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_level <= i_in.level_high;
            r_now   <= sdet_pkg::t_time'(i_in.now_ms);
        end
    end

    sdet_step u_step (
        .i_state       (r_st),
        .i_level_high  (r_level),
        .i_now         (r_now),
        .i_min_press   (r_min_press),
        .i_min_release (r_min_release),
        .o_state       (n_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase         <= sdet_pkg::PH_RELEASED;
            r_st.press_start   <= '0;
            r_st.release_start <= '0;
            r_st.pressed_ms    <= '0;
            r_st.released_ms   <= '0;
            r_st.debounced     <= 1'b0;
            r_st.press_pulse   <= 1'b0;
            r_st.release_pulse <= 1'b0;
        end else if (advance) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_is_pressed    <= n_st.debounced;
            r_press_event   <= n_st.press_pulse;
            r_release_event <= n_st.release_pulse;
            r_pressed_dur   <= sdet_pkg::t_dur'(n_st.pressed_ms);
            r_released_dur  <= sdet_pkg::t_dur'(n_st.released_ms);
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.is_pressed        = r_is_pressed;
    assign o_out.press_event       = r_press_event;
    assign o_out.release_event     = r_release_event;
    assign o_out.pressed_duration  = r_pressed_dur;
    assign o_out.released_duration = r_released_dur;

    // debounced level is tied to which half of the machine is active
    a_debounced_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.debounced == ((r_st.phase == sdet_pkg::PH_PRESSED) ||
                           (r_st.phase == sdet_pkg::PH_PEND_RELEASE)))
        else $error("debounced flag disagrees with phase");

    a_press_event_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.press_event) |-> o_out.is_pressed)
        else $error("press event without pressed state");

    a_release_event_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.release_event) |-> !o_out.is_pressed)
        else $error("release event while pressed");

    a_events_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.press_event && o_out.release_event))
        else $error("press and release events together");

endmodule
